// ===== hdl/tpbw_pkg.sv =====
// Shared types, constants and helpers for the tiled pixel blend write core.
package tpbw_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int TILE_W     = 18;
    localparam int PPU_W      = 16;
    localparam int EDGE_W     = 9;
    localparam int COUNT_W    = 10;
    localparam int EXT_W      = EDGE_W + COUNT_W;
    localparam int MUL_A_W    = POS_W + 1;
    localparam int MUL_B_W    = PPU_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PPU          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_EDGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 2'd3;

    localparam logic [PPU_W-1:0]   PPU_RESET          = 16'd256;
    localparam logic [EDGE_W-1:0]  TILE_EDGE_RESET    = 9'd64;
    localparam logic [COUNT_W-1:0] TILES_ACROSS_RESET = 10'd8;
    localparam logic [COUNT_W-1:0] TILES_DOWN_RESET   = 10'd8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE_X,
        S_SCALE_Y,
        S_SCALE_END,
        S_EXT_X,
        S_EXT_Y,
        S_CHECK,
        S_DIV_X,
        S_DIV_Y,
        S_TILE,
        S_ADDR,
        S_READ,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_cmd_t;

    // old + (target - old) / 4, quotient truncated toward zero
    function automatic logic [CHAN_W-1:0] blend_channel(
        input logic [CHAN_W-1:0] old_v,
        input logic [CHAN_W-1:0] tgt
    );
        logic signed [CHAN_W+1:0] d;
        logic signed [CHAN_W+1:0] q;
        d = $signed({2'b00, tgt}) - $signed({2'b00, old_v});
        q = d[CHAN_W+1] ? ((d + 10'sd3) >>> 2) : (d >>> 2);
        return CHAN_W'(old_v + q[CHAN_W-1:0]);
    endfunction

endpackage

// ===== hdl/tiled_pixel_blend_write_core.sv =====
// Top level: sequencer around one shared multiplier, a bit-serial divider and the pixel store.
// Blend: scale the position, form the tile extents, check bounds, divide x and then y by the
// tile edge (DW quotient bits each, DW = clog2(max(MAX_WIDTH,MAX_HEIGHT))), form tile and address,
// read, then write the pixel; load skips the scaling. Rejected points finish after the bounds check.
// The divider yields one quotient bit per cycle. One item at a time: busy drops in the cycle done shows.
// Reset restores the configuration registers to their defaults; the pixel store is not cleared.
module tiled_pixel_blend_write_core #(
    parameter int MAX_WIDTH  = tpbw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tpbw_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tpbw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpbw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic signed [tpbw_pkg::POS_W-1:0] pos_x,
    input  logic signed [tpbw_pkg::POS_W-1:0] pos_y,
    input  logic [tpbw_pkg::CHAN_W-1:0]       red,
    input  logic [tpbw_pkg::CHAN_W-1:0]       green,
    input  logic [tpbw_pkg::CHAN_W-1:0]       blue,
    output logic                              done,
    output logic                              written,
    output logic [tpbw_pkg::TILE_W-1:0]       tile_number,
    output logic [tpbw_pkg::CHAN_W-1:0]       out_red,
    output logic [tpbw_pkg::CHAN_W-1:0]       out_green,
    output logic [tpbw_pkg::CHAN_W-1:0]       out_blue
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DW    = (XW > YW) ? XW : YW;
    localparam int CW    = $clog2(DW + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = tpbw_pkg::POS_W;
    localparam int EW    = tpbw_pkg::EDGE_W;
    localparam int CH    = tpbw_pkg::CHAN_W;

    // configuration
    logic [tpbw_pkg::PPU_W-1:0]   ppu_reg;
    logic [EW-1:0]                tile_edge_reg;
    logic [tpbw_pkg::COUNT_W-1:0] tiles_across_reg;
    logic [tpbw_pkg::COUNT_W-1:0] tiles_down_reg;

    tpbw_pkg::state_t state_reg, state_next;

    logic                          op_reg;
    logic signed [PW-1:0]          sx_reg, sy_reg;
    logic [CH-1:0]                 r_reg, g_reg, b_reg;
    logic [PW-1:0]                 px_reg, py_reg;
    logic                          neg_reg;
    logic [tpbw_pkg::EXT_W-1:0]    ext_x_reg;
    logic signed [tpbw_pkg::PROD_W-1:0] prod_reg;
    logic [DW-1:0]                 dq_reg, qx_reg;
    logic [EW-1:0]                 rem_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [tpbw_pkg::TILE_W-1:0]   tile_reg;
    logic [AW-1:0]                 addr_reg;

    logic                          done_reg, written_reg;
    logic [tpbw_pkg::TILE_W-1:0]   tile_out_reg;
    logic [CH-1:0]                 out_r_reg, out_g_reg, out_b_reg;

    // shared multiplier operands
    logic signed [tpbw_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tpbw_pkg::MUL_B_W-1:0] mul_b;
    logic signed [tpbw_pkg::PROD_W-1:0]  mul_p;

    logic           accept;
    logic           reject;
    logic [EW-1:0]  rem_sh;
    logic           div_ge;
    logic [EW-1:0]  rem_new;
    logic [DW-1:0]  dq_new;
    logic           div_last;

    tpbw_pkg::store_cmd_t        cmd;
    logic [AW-1:0]               rd_addr;
    logic [tpbw_pkg::PIX_W-1:0]  rd_data;
    logic [tpbw_pkg::PIX_W-1:0]  wr_data;
    logic [CH-1:0]               nr, ng, nb;

    assign accept = start && (state_reg == tpbw_pkg::S_IDLE);
    assign busy   = (state_reg != tpbw_pkg::S_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppu_reg          <= tpbw_pkg::PPU_RESET;
            tile_edge_reg    <= tpbw_pkg::TILE_EDGE_RESET;
            tiles_across_reg <= tpbw_pkg::TILES_ACROSS_RESET;
            tiles_down_reg   <= tpbw_pkg::TILES_DOWN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpbw_pkg::CFG_PPU:          ppu_reg <= cfg_data;
                tpbw_pkg::CFG_TILE_EDGE:    tile_edge_reg <= cfg_data[EW-1:0];
                tpbw_pkg::CFG_TILES_ACROSS: tiles_across_reg <= cfg_data[9:0];
                tpbw_pkg::CFG_TILES_DOWN:   tiles_down_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            tpbw_pkg::S_SCALE_X:
            begin
                mul_a = tpbw_pkg::MUL_A_W'(sx_reg);
                mul_b = $signed({1'b0, ppu_reg});
            end
            tpbw_pkg::S_SCALE_Y:
            begin
                mul_a = tpbw_pkg::MUL_A_W'(sy_reg);
                mul_b = $signed({1'b0, ppu_reg});
            end
            tpbw_pkg::S_EXT_X:
            begin
                mul_a = $signed(tpbw_pkg::MUL_A_W'(tiles_across_reg));
                mul_b = $signed(tpbw_pkg::MUL_B_W'(tile_edge_reg));
            end
            tpbw_pkg::S_EXT_Y:
            begin
                mul_a = $signed(tpbw_pkg::MUL_A_W'(tiles_down_reg));
                mul_b = $signed(tpbw_pkg::MUL_B_W'(tile_edge_reg));
            end
            tpbw_pkg::S_TILE:
            begin
                // y quotient is complete in dq_reg
                mul_a = $signed(tpbw_pkg::MUL_A_W'(tiles_across_reg));
                mul_b = $signed(tpbw_pkg::MUL_B_W'(dq_reg));
            end
            tpbw_pkg::S_ADDR:
            begin
                mul_a = $signed({1'b0, py_reg});
                mul_b = tpbw_pkg::MUL_B_W'(MAX_WIDTH);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // restoring divide by tile_edge, one quotient bit per cycle
    assign rem_sh   = {rem_reg[EW-2:0], dq_reg[DW-1]};
    assign div_ge   = (rem_sh >= tile_edge_reg);
    assign rem_new  = div_ge ? (rem_sh - tile_edge_reg) : rem_sh;
    assign dq_new   = {dq_reg[DW-2:0], div_ge};
    assign div_last = (cnt_reg == CW'(1));

    assign reject = neg_reg
        || (px_reg >= PW'(ext_x_reg))
        || (py_reg >= PW'(prod_reg[tpbw_pkg::EXT_W-1:0]))
        || (px_reg >= PW'(MAX_WIDTH))
        || (py_reg >= PW'(MAX_HEIGHT));

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tpbw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = (operation == tpbw_pkg::OP_BLEND) ?
                                 tpbw_pkg::S_SCALE_X : tpbw_pkg::S_EXT_X;
                end
            end
            tpbw_pkg::S_SCALE_X:   state_next = tpbw_pkg::S_SCALE_Y;
            tpbw_pkg::S_SCALE_Y:   state_next = tpbw_pkg::S_SCALE_END;
            tpbw_pkg::S_SCALE_END: state_next = tpbw_pkg::S_EXT_X;
            tpbw_pkg::S_EXT_X:     state_next = tpbw_pkg::S_EXT_Y;
            tpbw_pkg::S_EXT_Y:     state_next = tpbw_pkg::S_CHECK;
            tpbw_pkg::S_CHECK:
            begin
                state_next = reject ? tpbw_pkg::S_IDLE : tpbw_pkg::S_DIV_X;
            end
            tpbw_pkg::S_DIV_X:
            begin
                if (div_last)
                begin
                    state_next = tpbw_pkg::S_DIV_Y;
                end
            end
            tpbw_pkg::S_DIV_Y:
            begin
                if (div_last)
                begin
                    state_next = tpbw_pkg::S_TILE;
                end
            end
            tpbw_pkg::S_TILE:      state_next = tpbw_pkg::S_ADDR;
            tpbw_pkg::S_ADDR:      state_next = tpbw_pkg::S_READ;
            tpbw_pkg::S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = tpbw_pkg::S_WRITE;
            end
            tpbw_pkg::S_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = tpbw_pkg::S_IDLE;
            end
            default:               state_next = tpbw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpbw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign rd_addr = prod_reg[AW-1:0] + px_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tpbw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_reg  <= operation;
                    sx_reg  <= pos_x;
                    sy_reg  <= pos_y;
                    r_reg   <= red;
                    g_reg   <= green;
                    b_reg   <= blue;
                    // load uses the integer part directly
                    px_reg  <= PW'(pos_x[PW-2:8]);
                    py_reg  <= PW'(pos_y[PW-2:8]);
                    neg_reg <= pos_x[PW-1] | pos_y[PW-1];
                end
            end
            tpbw_pkg::S_SCALE_X:
            begin
                prod_reg <= mul_p;
            end
            tpbw_pkg::S_SCALE_Y:
            begin
                px_reg   <= prod_reg[PW+15:16];
                neg_reg  <= prod_reg[tpbw_pkg::PROD_W-1];
                prod_reg <= mul_p;
            end
            tpbw_pkg::S_SCALE_END:
            begin
                py_reg  <= prod_reg[PW+15:16];
                neg_reg <= neg_reg | prod_reg[tpbw_pkg::PROD_W-1];
            end
            tpbw_pkg::S_EXT_X:
            begin
                prod_reg <= mul_p;
            end
            tpbw_pkg::S_EXT_Y:
            begin
                ext_x_reg <= prod_reg[tpbw_pkg::EXT_W-1:0];
                prod_reg  <= mul_p;
            end
            tpbw_pkg::S_CHECK:
            begin
                dq_reg  <= px_reg[DW-1:0];
                rem_reg <= '0;
                cnt_reg <= CW'(DW);
            end
            tpbw_pkg::S_DIV_X:
            begin
                if (div_last)
                begin
                    qx_reg  <= dq_new;
                    dq_reg  <= py_reg[DW-1:0];
                    rem_reg <= '0;
                    cnt_reg <= CW'(DW);
                end
                else
                begin
                    dq_reg  <= dq_new;
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
            tpbw_pkg::S_DIV_Y:
            begin
                dq_reg  <= dq_new;
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg - CW'(1);
            end
            tpbw_pkg::S_TILE:
            begin
                prod_reg <= mul_p;
            end
            tpbw_pkg::S_ADDR:
            begin
                tile_reg <= tpbw_pkg::TILE_W'(qx_reg) + prod_reg[tpbw_pkg::TILE_W-1:0];
                prod_reg <= mul_p;
            end
            tpbw_pkg::S_READ:
            begin
                addr_reg <= rd_addr;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (op_reg == tpbw_pkg::OP_BLEND)
        begin
            nr = tpbw_pkg::blend_channel(rd_data[23:16], r_reg);
            ng = tpbw_pkg::blend_channel(rd_data[15:8], g_reg);
            nb = tpbw_pkg::blend_channel(rd_data[7:0], b_reg);
        end
        else
        begin
            nr = r_reg;
            ng = g_reg;
            nb = b_reg;
        end
    end

    assign wr_data = {nr, ng, nb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ((state_reg == tpbw_pkg::S_CHECK) && reject)
                     || (state_reg == tpbw_pkg::S_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == tpbw_pkg::S_CHECK) && reject)
        begin
            written_reg  <= 1'b0;
            tile_out_reg <= '0;
            out_r_reg    <= '0;
            out_g_reg    <= '0;
            out_b_reg    <= '0;
        end
        else if (state_reg == tpbw_pkg::S_WRITE)
        begin
            written_reg  <= 1'b1;
            tile_out_reg <= tile_reg;
            out_r_reg    <= nr;
            out_g_reg    <= ng;
            out_b_reg    <= nb;
        end
    end

    tpbw_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .clk     (clk),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign done        = done_reg;
    assign written     = written_reg;
    assign tile_number = tile_out_reg;
    assign out_red     = out_r_reg;
    assign out_green   = out_g_reg;
    assign out_blue    = out_b_reg;

endmodule

// ===== hdl/tpbw_store.sv =====
// Pixel store: single write port, registered read port.
module tpbw_store #(
    parameter int MAX_WIDTH  = tpbw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tpbw_pkg::MAX_HEIGHT_DEF,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  tpbw_pkg::store_cmd_t         cmd,
    input  logic [AW-1:0]                rd_addr,
    input  logic [AW-1:0]                wr_addr,
    input  logic [tpbw_pkg::PIX_W-1:0]   wr_data,
    output logic [tpbw_pkg::PIX_W-1:0]   rd_data
);

    logic [tpbw_pkg::PIX_W-1:0] mem [DEPTH];
    logic [tpbw_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tpbw_check.sv =====
// Port-level checks for the tiled pixel blend write core, bound to the top level.
module tpbw_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        written,
    input logic [tpbw_pkg::TILE_W-1:0] tile_number,
    input logic [tpbw_pkg::CHAN_W-1:0] out_red,
    input logic [tpbw_pkg::CHAN_W-1:0] out_green,
    input logic [tpbw_pkg::CHAN_W-1:0] out_blue
);

    // a rejected point reports all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !written |-> tile_number == '0 && out_red == '0
                             && out_green == '0 && out_blue == '0)
        else $error("rejected word carries nonzero fields");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted start did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word strobed twice");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result word");

endmodule

bind tiled_pixel_blend_write_core tpbw_check u_tpbw_check (.*);
